@@ rtl/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared constants and codes for the bit string move block.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int WORDS_DEFAULT = 256;
    localparam int WORD_W        = 32;
    localparam int ADDR_W        = 8;
    localparam int BIT_W         = 5;
    localparam int CNT_W         = 14;
    localparam int IDX_W         = 3;
    localparam int OP_W          = 2;
    // bit positions cover a store of up to 65536 words
    localparam int POS_W         = 23;
    // wide enough to compare an address with any store depth
    localparam int WCMP_W        = 17;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

    localparam logic [IDX_W-1:0] REG_SRC_WORD  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_BIT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DST_WORD  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DST_BIT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_BIT_COUNT = 3'd4;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_ctl;

endpackage

@@ rtl/bsm_store.sv @@
// ----------------------------------------------------------------------------
// bsm_store
// Single port word store, one read or write a cycle, registered read data.
// ----------------------------------------------------------------------------
module bsm_store
    import bsm_pkg::*;
#(
    parameter int WORDS = WORDS_DEFAULT,
    parameter int AW    = $clog2(WORDS)
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  logic [WORD_W-1:0] i_wdata,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORD_W-1:0] r_rdata;

    // write or read one word
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bit_string_move_core.sv @@
// ----------------------------------------------------------------------------
// bit_string_move_core
// Word store with write, read and forward bit string move requests.
// ----------------------------------------------------------------------------
// Usage:
//   Configure source, destination and length through the cfg channel
//   (i_cfg_valid / o_cfg_ready, always ready) while the block is idle.
//   A request is taken when i_start is high and o_busy is low. Its result
//   shows on o_read_data / o_status for one cycle with o_strobe high; the
//   receiver cannot stall, so the result is simply gone after that cycle.
//   A write, an unused code and a refused or empty move answer in the cycle
//   after the request; a read first passes the registered store read and
//   then the registered result. A move runs one bit at a time through the
//   single store port: each bit reads its source word, then sets the bit;
//   each destination word touched is loaded and written back (the first bit
//   of each word reuses the load slot). The result follows the write back.
//   The destination word is held in a register while its bits are set, and
//   a source bit from that same word is taken from the register, which keeps
//   the overlap behavior of a bit-by-bit forward copy.
//   Reset clears the control state, strobe and config registers; the
//   datapath and store are undefined until written; no clearing pass runs.
// ----------------------------------------------------------------------------
module bit_string_move_core
    import bsm_pkg::*;
#(
    parameter int WORDS = WORDS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [WORD_W-1:0] i_data,
    output logic              o_strobe,
    output logic [WORD_W-1:0] o_read_data,
    output logic              o_status,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(WORDS);
    localparam logic [POS_W-1:0] LIMIT = POS_W'(WORDS) << BIT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDW  = 3'd1;
    localparam logic [2:0] ST_LDD  = 3'd2;
    localparam logic [2:0] ST_LDW  = 3'd3;
    localparam logic [2:0] ST_RS   = 3'd4;
    localparam logic [2:0] ST_RSW  = 3'd5;
    localparam logic [2:0] ST_WB   = 3'd6;

    logic [ADDR_W-1:0] r_src_word, r_dst_word;
    logic [BIT_W-1:0]  r_src_bit, r_dst_bit;
    logic [CNT_W-1:0]  r_bit_count;

    logic [2:0]        r_state, n_state;
    logic [POS_W-1:0]  r_sp, n_sp, r_dp, n_dp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_dw, n_dw;
    logic              r_strobe, n_strobe;
    logic [WORD_W-1:0] r_rd, n_rd;
    logic              r_st, n_st;

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    logic              accept;
    logic [WCMP_W-1:0] addr_ext;
    logic              addr_ok;
    logic [POS_W-1:0]  s_pos, d_pos, s_end, d_end;
    logic [POS_W-1:0]  wb_pos;
    logic              same_word, src_bit_val;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != ST_IDLE);
    assign accept      = i_start && !o_busy;
    assign addr_ext    = WCMP_W'(i_address);
    assign addr_ok     = addr_ext < WCMP_W'(WORDS);

    assign s_pos = (POS_W'(r_src_word) << BIT_W) + POS_W'(r_src_bit);
    assign d_pos = (POS_W'(r_dst_word) << BIT_W) + POS_W'(r_dst_bit);
    assign s_end = s_pos + POS_W'(r_bit_count);
    assign d_end = d_pos + POS_W'(r_bit_count);

    // last destination bit written, its word is the one to write back
    assign wb_pos = r_dp - POS_W'(1);

    assign same_word   = (r_sp[POS_W-1:BIT_W] == r_dp[POS_W-1:BIT_W]);
    assign src_bit_val = same_word ? r_dw[r_sp[BIT_W-1:0]] : mem_rdata[r_sp[BIT_W-1:0]];

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_word  <= '0;
            r_src_bit   <= '0;
            r_dst_word  <= '0;
            r_dst_bit   <= '0;
            r_bit_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SRC_WORD:  r_src_word  <= i_cfg_data[ADDR_W-1:0];
                REG_SRC_BIT:   r_src_bit   <= i_cfg_data[BIT_W-1:0];
                REG_DST_WORD:  r_dst_word  <= i_cfg_data[ADDR_W-1:0];
                REG_DST_BIT:   r_dst_bit   <= i_cfg_data[BIT_W-1:0];
                REG_BIT_COUNT: r_bit_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequence requests and the bit move
    always_comb begin
        n_state   = r_state;
        n_sp      = r_sp;
        n_dp      = r_dp;
        n_cnt     = r_cnt;
        n_dw      = r_dw;
        n_strobe  = 1'b0;
        n_rd      = '0;
        n_st      = 1'b0;
        mem_ctl   = '0;
        mem_addr  = addr_ext[AW-1:0];
        mem_wdata = i_data;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority case (i_operation)
                        OP_WRITE: begin
                            mem_ctl.en = addr_ok;
                            mem_ctl.we = 1'b1;
                            n_strobe   = 1'b1;
                        end
                        OP_READ: begin
                            if (addr_ok) begin
                                mem_ctl.en = 1'b1;
                                n_state    = ST_RDW;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        OP_MOVE: begin
                            if (s_end > LIMIT || d_end > LIMIT) begin
                                n_strobe = 1'b1;
                                n_st     = 1'b1;
                            end else if (r_bit_count == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_sp    = s_pos;
                                n_dp    = d_pos;
                                n_cnt   = r_bit_count;
                                n_state = ST_LDD;
                            end
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            ST_RDW: begin
                n_strobe = 1'b1;
                n_rd     = mem_rdata;
                n_state  = ST_IDLE;
            end
            ST_LDD: begin
                mem_ctl.en = 1'b1;
                mem_addr   = r_dp[AW+BIT_W-1:BIT_W];
                n_state    = ST_LDW;
            end
            ST_LDW: begin
                // take the destination word, fetch the first source word
                n_dw       = mem_rdata;
                mem_ctl.en = 1'b1;
                mem_addr   = r_sp[AW+BIT_W-1:BIT_W];
                n_state    = ST_RSW;
            end
            ST_RS: begin
                mem_ctl.en = 1'b1;
                mem_addr   = r_sp[AW+BIT_W-1:BIT_W];
                n_state    = ST_RSW;
            end
            ST_RSW: begin
                n_dw[r_dp[BIT_W-1:0]] = src_bit_val;
                n_sp  = r_sp + POS_W'(1);
                n_dp  = r_dp + POS_W'(1);
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1) || r_dp[BIT_W-1:0] == '1) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_RS;
                end
            end
            ST_WB: begin
                // write back the word just finished (r_dp already advanced)
                mem_ctl.en = 1'b1;
                mem_ctl.we = 1'b1;
                mem_addr   = wb_pos[AW+BIT_W-1:BIT_W];
                mem_wdata  = r_dw;
                if (r_cnt == '0) begin
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_LDD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // hold datapath registers
    always_ff @(posedge i_clk) begin
        r_sp  <= n_sp;
        r_dp  <= n_dp;
        r_cnt <= n_cnt;
        r_dw  <= n_dw;
        r_rd  <= n_rd;
        r_st  <= n_st;
    end

    bsm_store #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_strobe    = r_strobe;
    assign o_read_data = r_rd;
    assign o_status    = r_st;

    // a refused move never carries read data
    a_status_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status |-> o_read_data == '0)
        else $error("status set with nonzero read data");

    // a write request answers in the next cycle
    a_write_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_operation == OP_WRITE |=> o_strobe)
        else $error("write result missing");

    // a read request answers after the store read and the registered result
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_operation == OP_READ && addr_ok |=> ##1 o_strobe)
        else $error("read result missing");

    // a move never leaves the block while a word is still unwritten
    a_wb_before_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RSW |=> r_state == ST_RS || r_state == ST_WB)
        else $error("move left the bit loop without write back");

endmodule
